// ===== sv/sskr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the Shell sort key record block.
// No dependencies.
package sskr_pkg;

    localparam int INDEX_W = 7;
    localparam int FLOOR_W = 8;

    typedef struct packed {
        logic [INDEX_W-1:0] rec_index;
        logic [FLOOR_W-1:0] floor_key;
        logic               is_last;
    } in_item_t;

    typedef struct packed {
        logic [INDEX_W-1:0] out_index;
        logic [FLOOR_W-1:0] out_floor;
        logic               out_last;
        logic               overflow;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_LOAD,   // collecting records
        ST_GAP,    // start of a gap pass
        ST_ILOOP,  // outer insertion index
        ST_TEMP,   // capture record i
        ST_CMP,    // compare with record j-gap, shift back
        ST_PUT,    // drop held record into its slot
        ST_ORD,    // read record k for output
        ST_OWAIT   // load record k into the output register
    } state_t;

endpackage

// ===== sv/sskr_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module sskr_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/shell_sort_key_records.sv =====
// Shell sort of (index, floor) key records held in one record RAM.
// Load: one item per cycle until an item with is_last; input then held off until the last result.
// Sort: an insertion takes an index check, a capture, a compare per record tried, and a put if
// the walk reaches the first gap slot; a gap pass adds gap and closing index checks, all paced by
// the single RAM port. Output: a RAM read, then the output register, per result; the read waits
// for a free output register. Synchronous reset (aresetn low) clears control and flags, not the RAM.
`timescale 1ns / 1ps
module shell_sort_key_records #(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sskr_pkg::in_item_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sskr_pkg::out_item_t   m_data
);

    // Widths: addresses, and counters that must also hold CAPACITY itself.
    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int IW  = sskr_pkg::INDEX_W;
    localparam int FW  = sskr_pkg::FLOOR_W;
    // Only the low KEY_WIDTH bits of a floor take part; the rest read as zero.
    localparam int SKW = (KEY_WIDTH < FW) ? KEY_WIDTH : FW;
    localparam int RW  = IW + SKW;

    // Control state
    sskr_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] gap_reg, gap_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] k_reg, k_next;
    logic [RW-1:0] temp_reg, temp_next;   // record being inserted
    logic          m_valid_reg, m_valid_next;
    sskr_pkg::out_item_t m_data_reg, m_data_next;

    // RAM port signals
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [RW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [RW-1:0] ram_rdata;

    logic          s_fire;
    logic          has_room;
    logic [CW-1:0] count_inc;
    logic [CW-1:0] j_minus_g;
    logic [CW-1:0] j_minus_2g;
    logic          key_less;
    logic          out_free;

    assign s_fire     = s_valid && s_ready;
    assign has_room   = (count_reg < CW'(CAPACITY));
    assign count_inc  = has_room ? CW'(count_reg + 1'b1) : count_reg;
    assign j_minus_g  = j_reg - gap_reg;
    assign j_minus_2g = j_minus_g - gap_reg;
    // strict less-than: the held record stops at a record with an equal floor
    assign key_less   = (temp_reg[SKW-1:0] < ram_rdata[SKW-1:0]);
    // output register can take a new result by the next edge
    assign out_free   = !m_valid_reg || m_ready;

    sskr_ram #(
        .WIDTH(RW),
        .DEPTH(CAPACITY)
    ) u_rec_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next state and datapath registers
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        gap_next     = gap_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        temp_next    = temp_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            sskr_pkg::ST_LOAD: begin
                if (s_fire) begin
                    count_next = count_inc;
                    if (!has_room) begin
                        ovf_next = 1'b1;
                    end
                    if (s_data.is_last) begin
                        gap_next   = count_inc >> 1;
                        state_next = sskr_pkg::ST_GAP;
                    end
                end
            end
            sskr_pkg::ST_GAP: begin
                if (gap_reg == '0) begin
                    k_next     = '0;
                    state_next = sskr_pkg::ST_ORD;
                end else begin
                    i_next     = gap_reg;
                    state_next = sskr_pkg::ST_ILOOP;
                end
            end
            sskr_pkg::ST_ILOOP: begin
                if (i_reg >= count_reg) begin
                    gap_next   = gap_reg >> 1;
                    state_next = sskr_pkg::ST_GAP;
                end else begin
                    j_next     = i_reg;
                    state_next = sskr_pkg::ST_TEMP;
                end
            end
            sskr_pkg::ST_TEMP: begin
                temp_next  = ram_rdata;
                state_next = sskr_pkg::ST_CMP;
            end
            sskr_pkg::ST_CMP: begin
                if (key_less) begin
                    // record j-gap moves up to j; keep walking back if room
                    j_next = j_minus_g;
                    if (j_minus_g < gap_reg) begin
                        state_next = sskr_pkg::ST_PUT;
                    end
                end else begin
                    i_next     = CW'(i_reg + 1'b1);
                    state_next = sskr_pkg::ST_ILOOP;
                end
            end
            sskr_pkg::ST_PUT: begin
                i_next     = CW'(i_reg + 1'b1);
                state_next = sskr_pkg::ST_ILOOP;
            end
            sskr_pkg::ST_ORD: begin
                if (out_free) begin
                    state_next = sskr_pkg::ST_OWAIT;
                end
            end
            sskr_pkg::ST_OWAIT: begin
                m_valid_next          = 1'b1;
                m_data_next.out_index = ram_rdata[RW-1:SKW];
                m_data_next.out_floor = FW'(ram_rdata[SKW-1:0]);
                m_data_next.overflow  = ovf_reg;
                if (CW'(k_reg + 1'b1) == count_reg) begin
                    m_data_next.out_last = 1'b1;
                    count_next           = '0;
                    ovf_next             = 1'b0;
                    state_next           = sskr_pkg::ST_LOAD;
                end else begin
                    m_data_next.out_last = 1'b0;
                    k_next               = CW'(k_reg + 1'b1);
                    state_next           = sskr_pkg::ST_ORD;
                end
            end
            default: begin
                state_next = sskr_pkg::ST_LOAD;
            end
        endcase
    end

    // Outputs: handshake and RAM port
    always_comb begin
        s_ready   = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = j_reg[AW-1:0];
        ram_wdata = temp_reg;
        ram_raddr = i_reg[AW-1:0];

        case (state_reg)
            sskr_pkg::ST_LOAD: begin
                s_ready   = 1'b1;
                ram_we    = s_fire && has_room;
                ram_waddr = count_reg[AW-1:0];
                ram_wdata = {s_data.rec_index, s_data.floor_key[SKW-1:0]};
            end
            sskr_pkg::ST_ILOOP: begin
                ram_raddr = i_reg[AW-1:0];
            end
            sskr_pkg::ST_TEMP: begin
                ram_raddr = j_minus_g[AW-1:0];
            end
            sskr_pkg::ST_CMP: begin
                // shift: move the compared record up; else the held record lands at j
                ram_we    = 1'b1;
                ram_wdata = key_less ? ram_rdata : temp_reg;
                ram_raddr = j_minus_2g[AW-1:0];
            end
            sskr_pkg::ST_PUT: begin
                ram_we = 1'b1;
            end
            sskr_pkg::ST_ORD: begin
                ram_raddr = k_reg[AW-1:0];
            end
            sskr_pkg::ST_GAP, sskr_pkg::ST_OWAIT: begin
                ram_we = 1'b0;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sskr_pkg::ST_LOAD;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            gap_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            gap_reg     <= gap_next;
            m_valid_reg <= m_valid_next;
        end
        i_reg      <= i_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        temp_reg   <= temp_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Checks on the sequencer
    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("record count beyond capacity");

    a_gap_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        gap_reg <= (count_reg >> 1))
        else $error("gap larger than half the record count");

    a_walk_in_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sskr_pkg::ST_CMP) |-> (gap_reg != '0 && j_reg >= gap_reg))
        else $error("insertion walked below the first gap slot");

    a_out_reg_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sskr_pkg::ST_OWAIT) |-> !m_valid_reg)
        else $error("result loaded over one not yet taken");

endmodule
